### rtl/core/thfs_pkg.sv
`default_nettype none
package thfs_pkg;
    localparam int FRAC   = 24;
    localparam int NST    = 8;
    localparam int PW     = FRAC + 1;
    localparam int SCW    = 32;
    localparam int ACCW   = 56;
    localparam int DIVW   = FRAC + 16 + 1;
    localparam logic [PW-1:0] P_ONE  = PW'(1) << FRAC;
    localparam logic [SCW-1:0] SCALE_ONE = 32'd65536;
    localparam logic [SCW-1:0] SCALE_MAX = 32'hFFFF_FFFF;
    localparam logic [23:0] REG_RESET = 24'd83886;
    localparam logic [1:0] CFG_ERR = 2'd0;
    localparam logic [1:0] CFG_SD  = 2'd1;
    localparam logic [1:0] CFG_SM  = 2'd2;
    localparam logic [1:0] CFG_SC  = 2'd3;

    typedef struct packed {
        logic        first_site;
        logic        father_allele_a;
        logic        father_allele_b;
        logic        mother_allele_a;
        logic        mother_allele_b;
        logic        child_allele_a;
        logic        child_allele_b;
        logic [23:0] male_recomb_prob;
        logic [23:0] female_recomb_prob;
    } t_site;

    typedef struct packed {
        logic [NST-1:0][PW-1:0] state_prob;
        logic [SCW-1:0]         scale_factor;
    } t_result;

    // queued job: emission per state plus transition terms
    typedef struct packed {
        logic                   first_site;
        logic [NST-1:0][PW-1:0] emis;
        logic [23:0]            rm;
        logic [23:0]            rf;
    } t_job;
endpackage
`default_nettype wire

### rtl/core/thfs_if.sv
`default_nettype none
interface thfs_site_if (input wire logic i_clk);
    logic valid;
    logic ready;
    thfs_pkg::t_site data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface thfs_res_if (input wire logic i_clk);
    logic valid;
    logic ready;
    thfs_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/thfs_front.sv
`default_nettype none
module thfs_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [23:0]          i_err,
    input  wire thfs_pkg::t_site      i_site,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    output thfs_pkg::t_job            o_job,
    output logic                      o_valid,
    input  wire logic                 i_ready
);
    import thfs_pkg::*;
    // two-entry queue
    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job w_job;
    logic [1:0] fa, mo, ch;
    logic push, pop;

    always_comb begin
        fa = {i_site.father_allele_b, i_site.father_allele_a};
        mo = {i_site.mother_allele_b, i_site.mother_allele_a};
        ch = {i_site.child_allele_b, i_site.child_allele_a};
        w_job.first_site = i_site.first_site;
        w_job.rm = i_site.male_recomb_prob;
        w_job.rf = i_site.female_recomb_prob;
        for (int n = 0; n < NST; n++) begin
            if (ch[n & 1] == fa[(n >> 2) & 1] && ch[(n & 1) ^ 1] == mo[(n >> 1) & 1])
                w_job.emis[n] = P_ONE - {1'b0, i_err};
            else
                w_job.emis[n] = {1'b0, i_err};
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_ready;
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= w_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("ready while full");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !o_valid) else $error("valid while empty");
endmodule
`default_nettype wire

### rtl/core/thfs_back.sv
`default_nettype none
module thfs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [23:0]    i_sd,
    input  wire logic [23:0]    i_sm,
    input  wire logic [23:0]    i_sc,
    input  wire thfs_pkg::t_job i_job,
    input  wire logic           i_valid,
    output logic                o_ready,
    output thfs_pkg::t_result   o_res,
    output logic                o_valid,
    input  wire logic           i_ready
);
    import thfs_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_HAP = 4'd1, S_TT = 4'd2, S_MAC = 4'd3,
        S_EMI = 4'd4, S_SUM = 4'd5, S_DIV = 4'd6, S_NRM = 4'd7, S_OUT = 4'd8;

    logic [3:0] r_st;
    t_job r_job;
    logic [PW-1:0] r_fv [NST];
    logic [PW-1:0] r_v [NST];
    logic [PW-1:0] r_fd [2], r_fm [2], r_t [NST];
    logic [ACCW-1:0] r_acc;
    logic [2:0] r_n, r_p;
    logic [3:0] r_k;
    logic [PW+3:0] r_sum;
    logic [5:0] r_bit;
    logic [DIVW+PW+3:0] r_rem;
    logic [DIVW-1:0] r_quo;
    logic r_odd;
    logic [SCW-1:0] r_scale;
    logic r_oval;
    t_result r_res;

    // one shared multiplier, 25x25
    logic [PW-1:0] m_a, m_b;
    logic [2*PW-1:0] m_p;
    logic [PW-1:0] m_r;
    logic [ACCW-1:0] acc_rnd;
    assign m_p = m_a * m_b;
    assign m_r = PW'((m_p + (2*PW)'(1 << (FRAC-1))) >> FRAC);
    // accumulated sum rounded to nearest before the emission product
    assign acc_rnd = r_acc + ACCW'(1 << (FRAC-1));

    // hap terms: stay/move from r and switch s over four products per parent
    logic [PW-1:0] h_r, h_s;
    logic [2*PW:0] r_h0, r_h1;
    logic [2:0] r_ds;
    logic [2:0] pn;
    always_comb begin
        h_r = (r_k[3]) ? {1'b0, r_job.rf} : {1'b0, r_job.rm};
        h_s = (r_k[3]) ? {1'b0, i_sm} : {1'b0, i_sd};
        pn = r_p ^ r_n;
        m_a = '0;
        m_b = '0;
        unique case (r_st)
            S_HAP: begin
                unique case (r_k[1:0])
                    2'd0: begin m_a = P_ONE - h_r; m_b = P_ONE - h_s; end
                    2'd1: begin m_a = h_r;         m_b = h_s;         end
                    2'd2: begin m_a = h_r;         m_b = P_ONE - h_s; end
                    default: begin m_a = P_ONE - h_r; m_b = h_s;      end
                endcase
            end
            S_TT: begin
                if (!r_k[0]) begin
                    m_a = r_fd[r_p[2]];
                    m_b = r_fm[r_p[1]];
                end else begin
                    m_a = r_t[r_p];
                    m_b = r_p[0] ? {1'b0, i_sc} : P_ONE - {1'b0, i_sc};
                end
            end
            S_MAC: begin m_a = r_t[pn]; m_b = r_fv[r_p]; end
            S_EMI: begin m_a = acc_rnd[FRAC+PW-1:FRAC]; m_b = r_job.emis[r_n]; end
            default: ;
        endcase
    end

    // divider numerators and denominator
    logic [DIVW+PW+3:0] d_num;
    logic [DIVW+PW+3:0] d_den;
    always_comb begin
        if (r_odd) d_num = ({{(PW+4){1'b0}}, DIVW'(1) << (FRAC + 16)});
        else d_num = (DIVW+PW+4)'(r_v[r_n]) << FRAC;
        d_den = (DIVW+PW+4)'(r_sum);
    end

    logic [DIVW+PW+3:0] d_in;
    assign d_in = r_rem;

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_oval;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_oval <= 1'b0;
            for (int i = 0; i < NST; i++) r_fv[i] <= '0;
        end else begin
            if (r_st == S_OUT && (!r_oval || i_ready)) r_oval <= 1'b1;
            else if (r_oval && i_ready) r_oval <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_k <= '0;
                    if (i_job.first_site) begin
                        for (int i = 0; i < NST; i++) r_fv[i] <= i_job.emis[i] >> 3;
                        r_scale <= SCALE_ONE;
                        r_st <= S_OUT;
                    end else r_st <= S_HAP;
                end
                S_HAP: begin
                    if (!r_k[0]) r_h0 <= (2*PW+1)'(m_p);
                    else begin
                        logic [2*PW:0] s;
                        s = r_h0 + (2*PW+1)'(m_p) + (2*PW+1)'(1 << (FRAC-1));
                        if (!r_k[1]) begin
                            if (r_k[3]) r_fm[0] <= PW'(s >> FRAC);
                            else r_fd[0] <= PW'(s >> FRAC);
                        end else begin
                            if (r_k[3]) r_fm[1] <= PW'(s >> FRAC);
                            else r_fd[1] <= PW'(s >> FRAC);
                        end
                    end
                    if (r_k == 4'd11) begin
                        r_st <= S_TT; r_k <= '0; r_p <= '0;
                    end else if (r_k == 4'd3) r_k <= 4'd8;
                    else r_k <= r_k + 4'd1;
                end
                S_TT: begin
                    r_t[r_p] <= m_r;
                    r_k[0] <= ~r_k[0];
                    if (r_k[0]) begin
                        r_p <= r_p + 3'd1;
                        if (r_p == 3'd7) begin
                            r_st <= S_MAC; r_n <= '0; r_acc <= '0;
                        end
                    end
                end
                S_MAC: begin
                    r_acc <= r_acc + ACCW'(m_p);
                    r_p <= r_p + 3'd1;
                    if (r_p == 3'd7) r_st <= S_EMI;
                end
                S_EMI: begin
                    // m_a uses rounded acc
                    r_v[r_n] <= m_r;
                    r_n <= r_n + 3'd1;
                    r_acc <= '0;
                    if (r_n == 3'd7) begin r_st <= S_SUM; r_k <= '0; end
                    else r_st <= S_MAC;
                end
                S_SUM: begin
                    logic [PW+3:0] s;
                    s = '0;
                    for (int i = 0; i < NST; i++) s = s + (PW+4)'(r_v[i]);
                    r_sum <= s;
                    if (s == '0) begin
                        for (int i = 0; i < NST; i++) r_fv[i] <= '0;
                        r_scale <= SCALE_MAX;
                        r_st <= S_OUT;
                    end else begin
                        r_odd <= 1'b1;
                        r_n <= '0;
                        r_st <= S_NRM;
                    end
                end
                S_NRM: begin
                    // load numerator plus half divisor, then restoring divide
                    // over the 41 quotient bits
                    r_rem <= d_num + (d_den >> 1);
                    r_quo <= '0;
                    r_bit <= 6'(DIVW - 1);
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    logic [DIVW+PW+3:0] top;
                    top = d_in >> r_bit;
                    if (top >= d_den) begin
                        r_rem <= d_in - (d_den << r_bit);
                        r_quo <= r_quo | (DIVW'(1) << r_bit);
                    end
                    if (r_bit == '0) begin
                        if (r_odd) begin
                            logic [DIVW-1:0] q;
                            q = (top >= d_den) ? (r_quo | DIVW'(1)) : r_quo;
                            r_scale <= (q > DIVW'(SCALE_MAX)) ? SCALE_MAX : SCALE_MAX & SCW'(q);
                            r_odd <= 1'b0;
                            r_st <= S_NRM;
                        end else begin
                            logic [DIVW-1:0] q;
                            q = (top >= d_den) ? (r_quo | DIVW'(1)) : r_quo;
                            r_fv[r_n] <= (q > DIVW'(P_ONE)) ? P_ONE : PW'(q);
                            r_n <= r_n + 3'd1;
                            r_st <= (r_n == 3'd7) ? S_OUT : S_NRM;
                        end
                    end else r_bit <= r_bit - 6'd1;
                end
                S_OUT: if (!r_oval || i_ready) begin
                    for (int i = 0; i < NST; i++) r_res.state_prob[i] <= r_fv[i];
                    r_res.scale_factor <= r_scale;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != S_IDLE |-> !o_ready) else $error("ready while busy");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_OUT && !r_oval |=> r_oval) else $error("result not posted");
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> r_res.state_prob[0] <= P_ONE) else $error("state above one");
endmodule
`default_nettype wire

### rtl/core/trio_hmm_scaled_forward_step_unit.sv
`default_nettype none
// channel   dir  payload
// site_in   in   t_site: alleles, first_site, recombination probabilities
// res_out   out  t_result: eight Q1.24 state values, Q16.16 scale
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, four 24-bit registers
// a later site's time from accept to result is set by the shared 25x25 multiplier
// and the one-bit-per-cycle restoring divider (41 quotient bits plus a load per
// divide); a first site skips both and goes straight to the output state.
// reset is synchronous and clears control and stored states.
// a result waiting in the output register holds the back in its output state;
// the front queue holds two decoded words so input keeps flowing meanwhile until it fills.
module trio_hmm_scaled_forward_step_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    thfs_site_if.sink        site_in,
    thfs_res_if.source       res_out
);
    import thfs_pkg::*;
    logic [23:0] r_err, r_sd, r_sm, r_sc;
    t_job job;
    logic job_valid, job_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= REG_RESET; r_sd <= REG_RESET;
            r_sm <= REG_RESET;  r_sc <= REG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ERR: r_err <= i_cfg_data;
                CFG_SD:  r_sd  <= i_cfg_data;
                CFG_SM:  r_sm  <= i_cfg_data;
                default: r_sc  <= i_cfg_data;
            endcase
        end
    end

    thfs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_err(r_err),
        .i_site(site_in.data), .i_valid(site_in.valid), .o_ready(site_in.ready),
        .o_job(job), .o_valid(job_valid), .i_ready(job_ready)
    );

    thfs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sd(r_sd), .i_sm(r_sm), .i_sc(r_sc),
        .i_job(job), .i_valid(job_valid), .o_ready(job_ready),
        .o_res(res_out.data), .o_valid(res_out.valid), .i_ready(res_out.ready)
    );

    a_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid && job_ready |=> !job_ready) else $error("back took two words");
endmodule
`default_nettype wire
